// ----- rtl/core/canonical_huffman_bit_packer_macros.svh -----
// assertion macros shared by the bit packer modules
`ifndef CANONICAL_HUFFMAN_BIT_PACKER_MACROS_SVH
`define CANONICAL_HUFFMAN_BIT_PACKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CHBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/chbp_pkg.sv -----
// shared types and constants for the canonical huffman bit packer
`default_nettype none

package chbp_pkg;

  localparam int WORD_BITS   = 16;
  localparam int CODE_W      = 16;
  localparam int LEN_W       = 5;
  localparam int SYM_W       = 8;
  localparam int FILL_W      = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_DEFINE = 2'd1,
    OP_ENCODE = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } job_t;

endpackage

`default_nettype wire

// ----- rtl/core/chbp_front.sv -----
// front end: table build, code lookup and job issue
`default_nettype none

`include "canonical_huffman_bit_packer_macros.svh"

module chbp_front #(
  parameter int SYMBOL_COUNT    = 256,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic [1:0]                  opcode,
  input  wire logic [chbp_pkg::SYM_W-1:0]  symbol,
  input  wire logic [chbp_pkg::LEN_W-1:0]  code_length,
  output logic                             job_valid,
  output chbp_pkg::job_t                   job,
  input  wire logic                        job_full
);

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic [chbp_pkg::CODE_W+chbp_pkg::LEN_W-1:0] table_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]                     defined;

  logic [chbp_pkg::CODE_W-1:0] next_code;
  logic [chbp_pkg::LEN_W-1:0]  prev_len;

  logic                        s1_valid;
  logic                        s1_flush;
  logic                        rd_hit;
  logic [chbp_pkg::CODE_W-1:0] rd_code;
  logic [chbp_pkg::LEN_W-1:0]  rd_len;

  chbp_pkg::op_t               op;
  logic                        accept;
  logic                        advance;
  logic                        in_range;
  logic                        len_ok;
  logic                        def_en;
  logic [IDX_W-1:0]            idx;
  logic [chbp_pkg::CODE_W-1:0] shifted;
  logic [chbp_pkg::CODE_W-1:0] mask;

  assign op       = chbp_pkg::op_t'(opcode);
  assign idx      = symbol[IDX_W-1:0];
  assign in_range = (9'(symbol) < 9'(SYMBOL_COUNT));
  assign len_ok   = (code_length != '0) && (6'(code_length) <= 6'(MAX_CODE_LENGTH));

  assign job_valid  = s1_valid && (s1_flush || rd_hit);
  assign job.flush  = s1_flush;
  assign job.code   = rd_code;
  assign job.len    = rd_len;

  assign item_stall = job_valid && job_full;
  assign accept     = item_valid && !item_stall;
  assign advance    = s1_valid && !item_stall;
  assign def_en     = accept && (op == chbp_pkg::OP_DEFINE) && len_ok && in_range;

  always_comb begin
    if ((prev_len != '0) && (code_length > prev_len)) begin
      shifted = next_code << (code_length - prev_len);
    end else begin
      shifted = next_code;
    end
    mask = 16'hFFFF >> (5'd16 - code_length);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_code <= '0;
      prev_len  <= '0;
      defined   <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept && (op == chbp_pkg::OP_BEGIN)) begin
        next_code <= '0;
        prev_len  <= '0;
      end else if (def_en) begin
        next_code      <= shifted + 16'd1;
        prev_len       <= code_length;
        defined[idx]   <= 1'b1;
      end
      if (accept && ((op == chbp_pkg::OP_ENCODE) || (op == chbp_pkg::OP_FLUSH))) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // table write and registered lookup
  always_ff @(posedge clk) begin
    if (def_en) begin
      table_mem[idx] <= {code_length, shifted & mask};
    end
    if (accept) begin
      {rd_len, rd_code} <= table_mem[idx];
      rd_hit            <= defined[idx] && in_range && (op == chbp_pkg::OP_ENCODE);
      s1_flush          <= (op == chbp_pkg::OP_FLUSH);
    end
  end

  `CHBP_ASSERT_NOW(a_stall_needs_job, item_stall, s1_valid && job_valid, "stall without job")
  `CHBP_ASSERT_NOW(a_job_len_nonzero, job_valid && !job.flush, job.len != '0, "zero length job")

endmodule

`default_nettype wire

// ----- rtl/core/chbp_queue.sv -----
// short job queue between front and back end
`default_nettype none

`include "canonical_huffman_bit_packer_macros.svh"

module chbp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire chbp_pkg::job_t push_job,
  output logic                full,
  output logic                head_valid,
  output chbp_pkg::job_t      head_job,
  input  wire logic           pop
);

  chbp_pkg::job_t                 slots [chbp_pkg::QUEUE_DEPTH];
  logic [chbp_pkg::QPTR_W-1:0]    wr_ptr;
  logic [chbp_pkg::QPTR_W-1:0]    rd_ptr;
  logic [chbp_pkg::QCNT_W-1:0]    count;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (count == chbp_pkg::QCNT_W'(chbp_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `CHBP_ASSERT_NOW(a_count_bound, 1'b1, count <= chbp_pkg::QCNT_W'(chbp_pkg::QUEUE_DEPTH), "queue overrun")

endmodule

`default_nettype wire

// ----- rtl/core/chbp_back.sv -----
// back end: msb-first bit accumulator and output word register
`default_nettype none

`include "canonical_huffman_bit_packer_macros.svh"

module chbp_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            head_valid,
  input  wire chbp_pkg::job_t                  head_job,
  output logic                                 pop,
  output logic                                 word_valid,
  input  wire logic                            word_stall,
  output logic [chbp_pkg::WORD_BITS-1:0]       packed_word,
  output logic [chbp_pkg::LEN_W-1:0]           valid_bits
);

  logic [chbp_pkg::WORD_BITS-1:0]   acc;
  logic [chbp_pkg::FILL_W-1:0]      fill;
  logic [chbp_pkg::WORD_BITS-1:0]   acc_next;
  logic [chbp_pkg::FILL_W-1:0]      fill_next;
  logic                             emit;
  logic [chbp_pkg::WORD_BITS-1:0]   word_next;
  logic [chbp_pkg::LEN_W-1:0]       bits_next;
  logic [chbp_pkg::LEN_W-1:0]       total;
  logic [2*chbp_pkg::WORD_BITS-1:0] merged;

  assign pop   = head_valid && (!word_valid || !word_stall);
  assign total = chbp_pkg::LEN_W'(fill) + head_job.len;

  always_comb begin
    merged    = {acc, 16'h0000} |
                (32'(head_job.code) << (6'd32 - 6'(total)));
    acc_next  = acc;
    fill_next = fill;
    emit      = 1'b0;
    word_next = merged[31:16];
    bits_next = 5'd16;
    if (head_job.flush) begin
      word_next = acc;
      bits_next = chbp_pkg::LEN_W'(fill);
      emit      = (fill != '0);
      acc_next  = '0;
      fill_next = '0;
    end else if (total >= 5'd16) begin
      emit      = 1'b1;
      acc_next  = merged[15:0];
      fill_next = total[3:0];
    end else begin
      acc_next  = merged[31:16];
      fill_next = total[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      fill       <= '0;
      word_valid <= 1'b0;
    end else begin
      if (pop) begin
        acc  <= acc_next;
        fill <= fill_next;
      end
      if (pop && emit) begin
        word_valid <= 1'b1;
      end else if (!word_stall) begin
        word_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      packed_word <= word_next;
      valid_bits  <= bits_next;
    end
  end

  `CHBP_ASSERT_NEXT(a_flush_clears, pop && head_job.flush, fill == '0, "flush left bits")
  `CHBP_ASSERT_NOW(a_bits_range, word_valid, (valid_bits != '0) && (valid_bits <= 5'd16), "bad bit count")

endmodule

`default_nettype wire

// ----- rtl/core/canonical_huffman_bit_packer.sv -----
// canonical huffman code builder and msb-first 16-bit word packer
//
// item channel: item_valid/item_stall carry opcode, symbol and code_length;
// begin-table, define-symbol, encode-symbol and flush items may follow each
// other every cycle. define items assign canonical codes into a 256-entry
// table; encode items append the symbol's code to a 16-bit accumulator.
// word channel: word_valid/word_stall carry packed_word and valid_bits;
// valid_bits is 16 for a full word and 1..15 for a flushed partial word.
// word_valid rises once the item that completes a word has passed the table
// read register, the job queue and the output register. throughput: one item
// per cycle while item_stall is low; a define is visible to an encode
// accepted the very next cycle.
// reset: code counter, accumulator and table valid flags clear at once; no
// clearing pass. when the receiver stalls, the output word holds, the back
// end halts and the 4-entry job queue fills, after which item_stall rises.

`default_nettype none

module canonical_huffman_bit_packer #(
  parameter int SYMBOL_COUNT    = 256,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  symbol,
  input  wire logic [4:0]  code_length,
  output logic             word_valid,
  input  wire logic        word_stall,
  output logic [15:0]      packed_word,
  output logic [4:0]       valid_bits
);

  chbp_pkg::job_t job;
  chbp_pkg::job_t head_job;
  logic           job_valid;
  logic           job_full;
  logic           head_valid;
  logic           pop;

  chbp_front #(
    .SYMBOL_COUNT    (SYMBOL_COUNT),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .opcode      (opcode),
    .symbol      (symbol),
    .code_length (code_length),
    .job_valid   (job_valid),
    .job         (job),
    .job_full    (job_full)
  );

  chbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_valid),
    .push_job   (job),
    .full       (job_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  chbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .packed_word (packed_word),
    .valid_bits  (valid_bits)
  );

endmodule

`default_nettype wire

// ----- sim/tb_canonical_huffman_bit_packer.sv -----
// self-checking testbench for the canonical huffman bit packer: code table builds and word packing
`default_nettype none

module tb_canonical_huffman_bit_packer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN      = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 1600;

  class packer_scoreboard;
    typedef struct {
      logic [15:0] word;
      logic [4:0]  bits;
    } word_t;

    word_t       expected_words[$];
    logic [15:0] code_tbl[256];
    logic [4:0]  len_tbl[256];
    logic [15:0] run_code;
    logic [4:0]  last_len;
    logic [15:0] acc;
    int unsigned fill;
    int          errors;
    int          words_checked;
    int          partial_words;

    function new();
      foreach (code_tbl[i]) begin
        code_tbl[i] = '0;
        len_tbl[i]  = '0;
      end
      run_code      = '0;
      last_len      = '0;
      acc           = '0;
      fill          = 0;
      errors        = 0;
      words_checked = 0;
      partial_words = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // returns 1 when the beat changes state or yields a word
    function bit note_item(chbp_pkg::op_t op, logic [7:0] sym, logic [4:0] len);
      int unsigned total;
      logic [31:0] merged;
      word_t       w;
      unique case (op)
        chbp_pkg::OP_BEGIN: begin
          run_code = '0;
          last_len = '0;
          return 1'b1;
        end
        chbp_pkg::OP_DEFINE: begin
          if (len == 0 || len > MAX_LEN) return 1'b0;
          if (last_len != 0 && len > last_len) run_code = run_code << (len - last_len);
          code_tbl[sym] = 16'(run_code & ((32'd1 << len) - 32'd1));
          len_tbl[sym]  = len;
          last_len      = len;
          run_code      = run_code + 16'd1;
          return 1'b1;
        end
        chbp_pkg::OP_ENCODE: begin
          if (len_tbl[sym] == 0) return 1'b0;
          total  = fill + len_tbl[sym];
          merged = {acc, 16'h0000} | ({16'h0000, code_tbl[sym]} << (32 - total));
          if (total >= chbp_pkg::WORD_BITS) begin
            w.word = merged[31:16];
            w.bits = 5'(chbp_pkg::WORD_BITS);
            expected_words = {expected_words, w};
            acc  = merged[15:0];
            fill = total - chbp_pkg::WORD_BITS;
          end else begin
            acc  = merged[31:16];
            fill = total;
          end
          return 1'b1;
        end
        default: begin
          if (fill == 0) return 1'b0;
          w.word = acc;
          w.bits = 5'(fill);
          expected_words = {expected_words, w};
          acc  = '0;
          fill = 0;
          return 1'b1;
        end
      endcase
    endfunction

    function void check_word(logic [15:0] word, logic [4:0] bits);
      word_t w;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h valid_bits %0d",
                 $time, word, bits);
        return;
      end
      w = expected_words.pop_front();
      words_checked++;
      if (w.bits != chbp_pkg::WORD_BITS) partial_words++;
      if (word !== w.word) begin
        errors++;
        $display("%0t: packed_word expected %h actual %h", $time, w.word, word);
      end
      if (bits !== w.bits) begin
        errors++;
        $display("%0t: valid_bits expected %0d actual %0d", $time, w.bits, bits);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  opcode = chbp_pkg::OP_BEGIN;
  logic [7:0]  symbol = '0;
  logic [4:0]  code_length = '0;
  logic        word_valid;
  logic        word_stall = 1'b0;
  logic [15:0] packed_word;
  logic [4:0]  valid_bits;

  logic tx_quiet     = 1'b0;
  logic rx_quiet     = 1'b0;
  logic holdoff_go   = 1'b0;
  logic holdoff_done = 1'b0;
  int   items_used   = 0;
  int   tables_built = 0;

  packer_scoreboard sb = new();

  canonical_huffman_bit_packer dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .opcode      (opcode),
    .symbol      (symbol),
    .code_length (code_length),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .packed_word (packed_word),
    .valid_bits  (valid_bits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_item(input chbp_pkg::op_t op, input logic [7:0] sym,
                           input logic [4:0] len);
    while (!tx_quiet && $urandom_range(0, 99) < 8) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid  <= 1'b1;
    opcode      <= op;
    symbol      <= sym;
    code_length <= len;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (sb.note_item(op, sym, len)) items_used++;
    @(negedge clk);
  endtask

  initial begin : word_receiver
    int k;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (holdoff_go && !holdoff_done) begin
        word_stall <= 1'b1;
        for (k = 1; k < HOLD_CYCLES; k++) @(negedge clk);
        holdoff_done = 1'b1;
      end else begin
        word_stall <= !rx_quiet && ($urandom_range(0, 99) < 8);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && word_valid === 1'b1 && word_stall === 1'b0)
      sb.check_word(packed_word, valid_bits);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (word_valid === 1'b1 && !word_stall)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int         n_defs;
    int         n_enc;
    int         pick;
    int         len_pick;
    int         roll;
    int         keys[$];
    logic [7:0] defined_syms[$];
    bit         used[256];

    wait (!rst);
    @(negedge clk);

    // directed: empty cases, bad lengths, overflow, shrinking length, redefinition
    send_item(chbp_pkg::OP_ENCODE, 8'd0, 5'd0);
    send_item(chbp_pkg::OP_FLUSH, 8'hff, 5'd31);
    send_item(chbp_pkg::OP_DEFINE, 8'd5, 5'd0);
    send_item(chbp_pkg::OP_DEFINE, 8'd5, 5'd17);
    send_item(chbp_pkg::OP_DEFINE, 8'd5, 5'd31);
    send_item(chbp_pkg::OP_BEGIN, 8'd0, 5'd0);
    send_item(chbp_pkg::OP_DEFINE, 8'd0, 5'd1);
    send_item(chbp_pkg::OP_DEFINE, 8'd255, 5'd2);
    send_item(chbp_pkg::OP_DEFINE, 8'd7, 5'd3);
    send_item(chbp_pkg::OP_DEFINE, 8'd8, 5'd3);
    send_item(chbp_pkg::OP_DEFINE, 8'd9, 5'd16);
    send_item(chbp_pkg::OP_DEFINE, 8'd10, 5'd2);
    send_item(chbp_pkg::OP_ENCODE, 8'd255, 5'd0);
    send_item(chbp_pkg::OP_ENCODE, 8'd7, 5'd0);
    send_item(chbp_pkg::OP_ENCODE, 8'd8, 5'd0);
    send_item(chbp_pkg::OP_ENCODE, 8'd9, 5'd0);
    send_item(chbp_pkg::OP_ENCODE, 8'd10, 5'd0);
    send_item(chbp_pkg::OP_ENCODE, 8'd0, 5'd0);
    send_item(chbp_pkg::OP_ENCODE, 8'd100, 5'd0);
    send_item(chbp_pkg::OP_FLUSH, 8'd0, 5'd0);
    send_item(chbp_pkg::OP_DEFINE, 8'd0, 5'd16);
    send_item(chbp_pkg::OP_ENCODE, 8'd0, 5'd31);
    send_item(chbp_pkg::OP_ENCODE, 8'd0, 5'd0);
    send_item(chbp_pkg::OP_FLUSH, 8'd0, 5'd0);
    send_item(chbp_pkg::OP_BEGIN, 8'hff, 5'd31);

    items_used = 0;
    while (items_used < RANDOM_ITEMS) begin
      tables_built++;
      if (tables_built == 3) begin
        tx_quiet <= 1'b1;
        rx_quiet <= 1'b1;
      end
      if (tables_built == 6) begin
        tx_quiet <= 1'b0;
        rx_quiet <= 1'b0;
      end
      send_item(chbp_pkg::OP_BEGIN, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));

      // canonical order: by length, then by symbol
      n_defs = $urandom_range(2, 40);
      foreach (used[i]) used[i] = 1'b0;
      keys.delete();
      repeat (n_defs) begin
        do pick = $urandom_range(0, 255); while (used[pick]);
        used[pick] = 1'b1;
        len_pick = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, MAX_LEN);
        keys = {keys, len_pick * 256 + pick};
      end
      keys.sort();
      defined_syms.delete();
      foreach (keys[i]) begin
        if ($urandom_range(0, 99) < 3)
          send_item(chbp_pkg::OP_DEFINE, 8'($urandom_range(0, 255)),
                    $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31)));
        send_item(chbp_pkg::OP_DEFINE, 8'(keys[i] % 256), 5'(keys[i] / 256));
        defined_syms.push_front(8'(keys[i] % 256));
      end

      if (tables_built == 9) holdoff_go <= 1'b1;
      n_enc = $urandom_range(20, 100);
      repeat (n_enc) begin
        roll = $urandom_range(0, 99);
        if (roll < 85)
          send_item(chbp_pkg::OP_ENCODE,
                    defined_syms[$urandom_range(0, defined_syms.size() - 1)],
                    5'($urandom_range(0, 31)));
        else if (roll < 90)
          send_item(chbp_pkg::OP_FLUSH, 8'($urandom_range(0, 255)),
                    5'($urandom_range(0, 31)));
        else if (roll < 95)
          send_item(chbp_pkg::OP_ENCODE, 8'($urandom_range(0, 255)),
                    5'($urandom_range(0, 31)));
        else
          send_item(chbp_pkg::op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    5'($urandom_range(0, 31)));
      end
      if ($urandom_range(0, 1)) send_item(chbp_pkg::OP_FLUSH, 8'd0, 5'd0);
    end
    item_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d code tables and %0d effective random beats", tables_built,
             items_used);
    $display("%0d words checked, %0d of them partial words from flushes", sb.words_checked,
             sb.partial_words);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ----- canonical_huffman_bit_packer.f -----
+incdir+rtl/core
rtl/core/chbp_pkg.sv
rtl/core/chbp_front.sv
rtl/core/chbp_queue.sv
rtl/core/chbp_back.sv
rtl/core/canonical_huffman_bit_packer.sv
sim/tb_canonical_huffman_bit_packer.sv
